FILE: hw/rtl/stprs_pkg.sv
// Shared types and constants for the segment tree range sum block.
`default_nettype none
package stprs_pkg;

   localparam int LEAVES_DEF = 1024;
   localparam int ACTION_W   = 2;
   localparam int INDEX_W    = 10;
   localparam int DATA_W     = 32;

   localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   typedef struct packed {
      logic capture;
      logic clr_step;
      logic add_read;
      logic add_leaf;
      logic add_up;
      logic q_left;
      logic q_right;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic sweep_last;
      logic leaf_ok;
      logic parent_root;
      logic a_lt_b;
   } sts_type;

endpackage
`default_nettype wire

FILE: hw/rtl/segment_tree_point_add_range_sum_top.sv
// Top level of the sum segment tree with point add and range sum query.
// Sum segment tree over LEAVES 32-bit counters held in one 2*LEAVES word RAM
// (leaves at entries LEAVES..2*LEAVES-1). One request word carries an add, a
// query or a clear; only a query returns a response word. Sums wrap modulo
// 2^32. Items are processed one at a time and the single RAM read port sets
// the pace: an add reads the leaf, writes the leaf, then does one sibling
// read and parent write per level; a query takes two steps per level, each
// reading at most one node; and a clear zeroes one RAM entry per cycle.
// After reset the same clearing pass runs with req_stall high. A finished
// query sum sits in an output register, so the next request is taken while
// that response waits on rsp_stall. Adds to a leaf at or beyond LEAVES are
// dropped, range_high is clamped to LEAVES-1, an empty range returns 0 and
// action code 3 does nothing.
`default_nettype none
module segment_tree_point_add_range_sum_top #(
   parameter int LEAVES = stprs_pkg::LEAVES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [stprs_pkg::ACTION_W-1:0]         req_action,
   input  logic [stprs_pkg::INDEX_W-1:0]          req_leaf_index,
   input  logic signed [stprs_pkg::DATA_W-1:0]   req_delta,
   input  logic [stprs_pkg::INDEX_W-1:0]          req_range_low,
   input  logic [stprs_pkg::INDEX_W-1:0]          req_range_high,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [stprs_pkg::DATA_W-1:0]   rsp_range_sum
);
   import stprs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   stprs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   stprs_dp #(
      .LEAVES (LEAVES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_leaf_index (req_leaf_index),
      .req_delta      (req_delta),
      .req_range_low  (req_range_low),
      .req_range_high (req_range_high),
      .rsp_range_sum  (rsp_range_sum),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
`default_nettype wire

FILE: hw/rtl/stprs_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module stprs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/stprs_ctrl.sv
// Controller state machine: sequences clear sweeps, leaf updates and range walks.
`default_nettype none
module stprs_ctrl (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [stprs_pkg::ACTION_W-1:0]         req_action,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output stprs_pkg::cmd_type                     cmd,
   input  stprs_pkg::sts_type                     sts
);
   import stprs_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ADD0,
      S_ADD1,
      S_ADD2,
      S_QA,
      S_QB,
      S_QOUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.sweep_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_action)
                  ACT_ADD:   state_in = S_ADD0;
                  ACT_QUERY: state_in = S_QA;
                  ACT_CLEAR: state_in = S_CLEAR;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ADD0: begin
            if (sts.leaf_ok) begin
               cmd.add_read = 1'b1;
               state_in     = S_ADD1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_ADD1: begin
            cmd.add_leaf = 1'b1;
            state_in     = S_ADD2;
         end
         S_ADD2: begin
            cmd.add_up = 1'b1;
            if (sts.parent_root) begin
               state_in = S_IDLE;
            end
         end
         S_QA: begin
            if (sts.a_lt_b) begin
               cmd.q_left = 1'b1;
               state_in   = S_QB;
            end else begin
               state_in = S_QOUT;
            end
         end
         S_QB: begin
            cmd.q_right = 1'b1;
            state_in    = S_QA;
         end
         S_QOUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/stprs_dp.sv
// Datapath: node store, walk pointers, adder and result word register.
`default_nettype none
module stprs_dp #(
   parameter int LEAVES = stprs_pkg::LEAVES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [stprs_pkg::INDEX_W-1:0]          req_leaf_index,
   input  logic signed [stprs_pkg::DATA_W-1:0]   req_delta,
   input  logic [stprs_pkg::INDEX_W-1:0]          req_range_low,
   input  logic [stprs_pkg::INDEX_W-1:0]          req_range_high,
   output logic signed [stprs_pkg::DATA_W-1:0]   rsp_range_sum,
   input  stprs_pkg::cmd_type                     cmd,
   output stprs_pkg::sts_type                     sts
);
   import stprs_pkg::*;

   localparam int DEPTH = 2 * LEAVES;
   localparam int AW    = $clog2(DEPTH);
   localparam int NW    = AW + 1;
   localparam int XW    = (NW > INDEX_W + 1) ? NW : INDEX_W + 1;
   localparam logic [AW-1:0] LEAF_BASE  = AW'(LEAVES);
   localparam logic [AW-1:0] SWEEP_LAST = AW'(DEPTH - 1);
   localparam logic [AW-1:0] ROOT       = AW'(1);
   localparam logic [NW-1:0] BASE_N     = NW'(LEAVES);
   localparam logic [XW-1:0] LEAVES_X   = XW'(LEAVES);

   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [AW-1:0]     p_ff, p_in;
   logic              leaf_ok_ff, leaf_ok_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [NW-1:0]     a_ff, a_in;
   logic [NW-1:0]     b_ff, b_in;
   logic [DATA_W-1:0] acc_ff, acc_in;
   logic              pend_ff, pend_in;
   logic [DATA_W-1:0] out_ff, out_in;

   logic [XW-1:0]     hi_x, lo_x, hi_sat;
   logic [NW-1:0]     b_start;
   logic [AW-1:0]     parent;
   logic [NW-1:0]     b_dec;
   logic [DATA_W-1:0] leaf_sum, up_sum;

   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [DATA_W-1:0] wr_data, rd_data;

   stprs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hi_x     = XW'(req_range_high);
   assign lo_x     = XW'(req_range_low);
   assign hi_sat   = (hi_x >= LEAVES_X) ? (LEAVES_X - XW'(1)) : hi_x;
   assign b_start  = NW'(hi_sat) + BASE_N + NW'(1);
   assign parent   = p_ff >> 1;
   assign b_dec    = b_ff - NW'(1);
   assign leaf_sum = rd_data + delta_ff;
   assign up_sum   = val_ff + rd_data;

   assign sts.sweep_last  = (sweep_ff == SWEEP_LAST);
   assign sts.leaf_ok     = leaf_ok_ff;
   assign sts.parent_root = (parent == ROOT);
   assign sts.a_lt_b      = (a_ff < b_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = '0;
      rd_en   = 1'b0;
      rd_addr = p_ff;
      if (cmd.clr_step) begin
         wr_en = 1'b1;
      end
      if (cmd.add_read) begin
         rd_en = 1'b1;
      end
      if (cmd.add_leaf) begin
         wr_en   = 1'b1;
         wr_addr = p_ff;
         wr_data = leaf_sum;
         rd_en   = 1'b1;
         rd_addr = p_ff ^ ROOT;
      end
      if (cmd.add_up) begin
         wr_en   = 1'b1;
         wr_addr = parent;
         wr_data = up_sum;
         rd_en   = 1'b1;
         rd_addr = parent ^ ROOT;
      end
      if (cmd.q_left) begin
         rd_en   = a_ff[0];
         rd_addr = a_ff[AW-1:0];
      end
      if (cmd.q_right) begin
         rd_en   = b_ff[0];
         rd_addr = b_dec[AW-1:0];
      end
   end

   always_comb begin
      sweep_in   = sweep_ff;
      p_in       = p_ff;
      leaf_ok_in = leaf_ok_ff;
      delta_in   = delta_ff;
      val_in     = val_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      acc_in     = pend_ff ? (acc_ff + rd_data) : acc_ff;
      pend_in    = 1'b0;
      out_in     = out_ff;
      if (cmd.clr_step) begin
         sweep_in = sts.sweep_last ? '0 : (sweep_ff + AW'(1));
      end
      if (cmd.capture) begin
         p_in       = AW'(req_leaf_index) + LEAF_BASE;
         leaf_ok_in = (XW'(req_leaf_index) < LEAVES_X);
         delta_in   = req_delta;
         b_in       = b_start;
         a_in       = (lo_x <= hi_sat) ? (NW'(lo_x) + BASE_N) : b_start;
         acc_in     = '0;
      end
      if (cmd.add_leaf) begin
         val_in = leaf_sum;
      end
      if (cmd.add_up) begin
         val_in = up_sum;
         p_in   = parent;
      end
      if (cmd.q_left) begin
         pend_in = a_ff[0];
         if (a_ff[0]) begin
            a_in = a_ff + NW'(1);
         end
      end
      if (cmd.q_right) begin
         pend_in = b_ff[0];
         a_in    = a_ff >> 1;
         b_in    = b_ff >> 1;
      end
      if (cmd.load_out) begin
         out_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         sweep_ff <= sweep_in;
         pend_ff  <= pend_in;
      end
      p_ff       <= p_in;
      leaf_ok_ff <= leaf_ok_in;
      delta_ff   <= delta_in;
      val_ff     <= val_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      acc_ff     <= acc_in;
      out_ff     <= out_in;
   end

   assign rsp_range_sum = out_ff;

endmodule
`default_nettype wire
